>>> rtl/core/heightmap_vertex_normal_stream_core_assert.svh
// Assertion macros used by the checker file.
`ifndef HEIGHTMAP_VERTEX_NORMAL_STREAM_CORE_ASSERT_SVH
`define HEIGHTMAP_VERTEX_NORMAL_STREAM_CORE_ASSERT_SVH

// Same-cycle implication, masked while reset is held.
`define HVNS_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, also checked during reset.
`define HVNS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/hvns_pkg.sv
package hvns_pkg;

    // Default largest map edge
    localparam int HVNS_MAX_GRID = 1024;

    // Configuration register indexes
    localparam logic [1:0] CFG_GRID_SIZE = 2'd0;
    localparam logic [1:0] CFG_SPACING   = 2'd1;

    localparam logic [10:0] GRID_RESET    = 11'd256;
    localparam logic [9:0]  SPACING_RESET = 10'd1;

    // Squares and squared norm fit in 29 bits
    localparam int SQ_W = 29;
    // Normalized magnitude, up to 16384
    localparam int M_W  = 15;

    // Depth of the work and result queues
    localparam int QUEUE_DEPTH = 2;

    localparam logic signed [15:0] NORMAL_ONE  = 16'sd16384;
    localparam logic signed [15:0] NORMAL_ZERO = 16'sd0;
    localparam logic [8:0]         HEIGHT_BIAS = 9'd100;

    // Work request from front to back
    typedef struct packed {
        logic [7:0]        center;
        logic [7:0]        cur;
        logic signed [8:0] vx;
        logic signed [8:0] vz;
        logic              interior;
        logic              last_row;
        logic              map_last;
    } t_task;

    // One result item
    typedef struct packed {
        logic signed [19:0] pos_x;
        logic signed [8:0]  height_tenths;
        logic signed [19:0] pos_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic               run_last;
        logic               map_last;
    } t_result;

endpackage

>>> rtl/core/hvns_ram.sv
module hvns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> rtl/core/hvns_fifo.sv
module hvns_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

>>> rtl/core/hvns_front.sv
module hvns_front import hvns_pkg::*; #(
    parameter int MAX_GRID = HVNS_MAX_GRID,
    localparam int CW  = $clog2(MAX_GRID),
    localparam int GW  = $clog2(MAX_GRID + 1),
    localparam int GEW = (GW > 11) ? GW : 11
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_restart,
    input  logic [GEW-1:0] i_grid,
    input  logic           i_push,
    input  logic [7:0]     i_height,
    output logic           o_full,
    input  logic           i_task_room,
    output logic           o_task_push,
    output t_task          o_task,
    output logic [CW-1:0]  o_col,
    output logic [CW-1:0]  o_vrow
);

    typedef enum logic [2:0] {
        F_IDLE  = 3'b001,
        F_READ  = 3'b010,
        F_WRITE = 3'b100
    } t_fstate;

    t_fstate       r_state;
    t_fstate       n_state;
    logic [CW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [7:0]    r_cur;
    logic [7:0]    r_center;
    logic [7:0]    r_down;
    logic [7:0]    r_left;

    logic          accept;
    logic [GEW-1:0] grid_m1;
    logic          col_last;
    logic          row_last;
    logic [CW-1:0] next_addr;
    logic [CW-1:0] prev_raddr;
    logic [7:0]    prev_rdata;
    logic [7:0]    older_rdata;

    assign o_full   = (r_state != F_IDLE) || !i_task_room;
    assign accept   = i_push && !o_full;
    assign grid_m1  = i_grid - GEW'(1);
    assign col_last = (GEW'(r_col) == grid_m1);
    assign row_last = (GEW'(r_row) == grid_m1);

    // Right neighbor address; last column has no right neighbor
    assign next_addr  = col_last ? r_col : r_col + CW'(1);
    assign prev_raddr = (r_state == F_READ) ? next_addr : r_col;

    // Line buffer holding the latest row
    hvns_ram #(.WIDTH(8), .DEPTH(MAX_GRID)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == F_WRITE),
        .i_waddr (r_col),
        .i_wdata (r_cur),
        .i_raddr (prev_raddr),
        .o_rdata (prev_rdata)
    );

    // Line buffer holding the row before that
    hvns_ram #(.WIDTH(8), .DEPTH(MAX_GRID)) u_older_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == F_READ),
        .i_waddr (r_col),
        .i_wdata (prev_rdata),
        .i_raddr (r_col),
        .o_rdata (older_rdata)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (accept) n_state = F_READ;
            F_READ:  n_state = F_WRITE;
            F_WRITE: n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            if (i_restart) begin
                r_row <= '0;
                r_col <= '0;
            end else if (r_state == F_WRITE) begin
                if (col_last) begin
                    r_col <= '0;
                    r_row <= row_last ? '0 : r_row + CW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    // Payload capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cur <= i_height;
        end
        if (r_state == F_READ) begin
            r_center <= prev_rdata;
            r_down   <= older_rdata;
        end
        if (r_state == F_WRITE) begin
            r_left <= r_center;
        end
    end

    // Work request, built while the right neighbor is on the read port
    assign o_task_push     = (r_state == F_WRITE) && (r_row != '0);
    assign o_task.center   = r_center;
    assign o_task.cur      = r_cur;
    assign o_task.vx       = $signed({1'b0, r_left}) - $signed({1'b0, prev_rdata});
    assign o_task.vz       = $signed({1'b0, r_down}) - $signed({1'b0, r_cur});
    assign o_task.interior = (r_row > CW'(1)) && (r_col != '0) && !col_last;
    assign o_task.last_row = row_last;
    assign o_task.map_last = row_last && col_last;
    assign o_col           = r_col;
    assign o_vrow          = r_row - CW'(1);

endmodule

>>> rtl/core/hvns_norm.sv
module hvns_norm import hvns_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SQ_W-1:0]     i_sq,
    input  logic [SQ_W-1:0]     i_n2,
    input  logic                i_neg,
    output logic                o_busy,
    output logic signed [15:0]  o_value
);

    // Builds m bit by bit, largest m with (2m-1)^2 * n2 <= sq * 2^30.
    // a = m^2 n2, b = m n2, x = 2 d b, y = d^2 n2, z = d n2 for step weight d.
    logic [3:0]      r_k;
    logic            r_phase;
    logic            r_busy;
    logic            r_neg;
    logic [M_W-1:0]  r_m;
    logic [59:0]     r_a;
    logic [43:0]     r_b;
    logic [59:0]     r_x;
    logic [57:0]     r_y;
    logic [43:0]     r_z;
    logic [59:0]     r_ac;
    logic [43:0]     r_bc;
    logic [58:0]     r_l;
    logic [SQ_W-1:0] r_n2;

    logic [63:0]     lhs;
    logic [63:0]     rhs;
    logic            fit;
    logic [59:0]     x_sel;

    assign lhs   = {2'b00, r_ac, 2'b00} + 64'(r_n2);
    assign rhs   = 64'(r_l) + {18'd0, r_bc, 2'b00};
    assign fit   = (lhs <= rhs);
    assign x_sel = fit ? r_x + 60'({r_y, 1'b0}) : r_x;

    assign o_busy  = r_busy;
    assign o_value = r_neg ? -$signed({1'b0, r_m}) : $signed({1'b0, r_m});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_phase <= 1'b0;
        end else if (r_busy) begin
            r_phase <= !r_phase;
            if (r_phase && (r_k == 4'd0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Recurrence: candidate sums, then compare and commit
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_k   <= 4'(M_W - 1);
            r_m   <= '0;
            r_a   <= '0;
            r_b   <= '0;
            r_x   <= '0;
            r_y   <= 58'(i_n2) << 28;
            r_z   <= 44'(i_n2) << 14;
            r_l   <= 59'(i_sq) << 30;
            r_n2  <= i_n2;
            r_neg <= i_neg;
        end else if (r_busy) begin
            if (!r_phase) begin
                r_ac <= r_a + r_x + 60'(r_y);
                r_bc <= r_b + r_z;
            end else begin
                if (fit) begin
                    r_a <= r_ac;
                    r_b <= r_bc;
                    r_m <= r_m | (M_W'(1) << r_k);
                end
                r_x <= x_sel >> 1;
                r_y <= r_y >> 2;
                r_z <= r_z >> 1;
                r_k <= r_k - 4'd1;
            end
        end
    end

endmodule

>>> rtl/core/hvns_back.sv
module hvns_back import hvns_pkg::*; #(
    parameter int MAX_GRID = HVNS_MAX_GRID,
    localparam int CW  = $clog2(MAX_GRID),
    localparam int GW  = $clog2(MAX_GRID + 1),
    localparam int GEW = (GW > 11) ? GW : 11,
    localparam int PMW = CW + 10,
    localparam int EW  = GEW + 10,
    localparam int XW  = EW + 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [GEW-1:0] i_grid,
    input  logic [9:0]     i_spacing,
    input  logic           i_task_valid,
    input  t_task          i_task,
    input  logic [CW-1:0]  i_col,
    input  logic [CW-1:0]  i_vrow,
    output logic           o_task_pop,
    input  logic           i_res_room,
    output logic           o_res_push,
    output t_result        o_res
);

    typedef enum logic [6:0] {
        B_IDLE  = 7'b0000001,
        B_MUL   = 7'b0000010,
        B_SUM   = 7'b0000100,
        B_START = 7'b0001000,
        B_WAIT  = 7'b0010000,
        B_OUT0  = 7'b0100000,
        B_OUT1  = 7'b1000000
    } t_bstate;

    t_bstate         r_state;
    t_bstate         n_state;
    t_task           r_task;
    logic [CW-1:0]   r_col;
    logic [CW-1:0]   r_vrow;
    logic [14:0]     r_vy;
    logic [SQ_W-1:0] r_sq_x;
    logic [SQ_W-1:0] r_sq_y;
    logic [SQ_W-1:0] r_sq_z;
    logic [SQ_W-1:0] r_n2;
    logic [PMW-1:0]  r_pmx;
    logic [PMW-1:0]  r_pmz;
    logic [EW-1:0]   r_ext;
    logic [19:0]     r_pos_x;
    logic [19:0]     r_pos_z0;
    logic [19:0]     r_pos_z1;

    logic [7:0]         abs_x;
    logic [7:0]         abs_z;
    logic [XW-1:0]      half;
    logic               norm_busy;
    logic               busy_y;
    logic               busy_z;
    logic signed [15:0] nrm_x;
    logic signed [15:0] nrm_y;
    logic signed [15:0] nrm_z;

    assign abs_x = r_task.vx[8] ? 8'(-r_task.vx) : r_task.vx[7:0];
    assign abs_z = r_task.vz[8] ? 8'(-r_task.vz) : r_task.vz[7:0];
    assign half  = XW'(r_ext >> 1);

    // One normalizer per component, started together
    hvns_norm u_norm_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (r_state == B_START),
        .i_sq (r_sq_x), .i_n2 (r_n2), .i_neg (r_task.vx[8]),
        .o_busy (norm_busy), .o_value (nrm_x)
    );
    hvns_norm u_norm_y (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (r_state == B_START),
        .i_sq (r_sq_y), .i_n2 (r_n2), .i_neg (1'b0),
        .o_busy (busy_y), .o_value (nrm_y)
    );
    hvns_norm u_norm_z (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (r_state == B_START),
        .i_sq (r_sq_z), .i_n2 (r_n2), .i_neg (r_task.vz[8]),
        .o_busy (busy_z), .o_value (nrm_z)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  if (i_task_valid) n_state = B_MUL;
            B_MUL:   n_state = B_SUM;
            B_SUM:   n_state = r_task.interior ? B_START : B_OUT0;
            B_START: n_state = B_WAIT;
            B_WAIT:  if (!(norm_busy || busy_y || busy_z)) n_state = B_OUT0;
            B_OUT0:  if (i_res_room) n_state = r_task.last_row ? B_OUT1 : B_IDLE;
            B_OUT1:  if (i_res_room) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_task_pop = (r_state == B_IDLE) && i_task_valid;

    // Arithmetic stages
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_task <= i_task;
                r_col  <= i_col;
                r_vrow <= i_vrow;
                r_vy   <= (15'(i_spacing) << 4) + (15'(i_spacing) << 2);
            end
            B_MUL: begin
                r_sq_x <= SQ_W'(abs_x * abs_x);
                r_sq_z <= SQ_W'(abs_z * abs_z);
                r_sq_y <= SQ_W'(r_vy * r_vy);
                r_pmx  <= PMW'(r_col) * PMW'(i_spacing);
                r_pmz  <= PMW'(r_vrow) * PMW'(i_spacing);
                r_ext  <= EW'(i_grid - GEW'(1)) * EW'(i_spacing);
            end
            B_SUM: begin
                r_n2     <= r_sq_x + r_sq_y + r_sq_z;
                r_pos_x  <= 20'(XW'(r_pmx) - half);
                r_pos_z0 <= 20'(XW'(r_pmz) - half);
                r_pos_z1 <= 20'(XW'(r_pmz) + XW'(i_spacing) - half);
            end
            default: begin
            end
        endcase
    end

    // Result assembly
    always_comb begin
        o_res_push          = ((r_state == B_OUT0) || (r_state == B_OUT1)) && i_res_room;
        o_res.pos_x         = r_pos_x;
        o_res.normal_x      = NORMAL_ZERO;
        o_res.normal_y      = NORMAL_ONE;
        o_res.normal_z      = NORMAL_ZERO;
        if (r_state == B_OUT1) begin
            o_res.height_tenths = $signed({1'b0, r_task.cur} - HEIGHT_BIAS);
            o_res.pos_z         = r_pos_z1;
            o_res.run_last      = 1'b1;
            o_res.map_last      = r_task.map_last;
        end else begin
            o_res.height_tenths = $signed({1'b0, r_task.center} - HEIGHT_BIAS);
            o_res.pos_z         = r_pos_z0;
            o_res.run_last      = !r_task.last_row;
            o_res.map_last      = 1'b0;
            if (r_task.interior) begin
                o_res.normal_x = nrm_x;
                o_res.normal_y = nrm_y;
                o_res.normal_z = nrm_z;
            end
        end
    end

endmodule

>>> rtl/core/heightmap_vertex_normal_stream_core.sv
// Heightmap vertex stream: height bytes of a square map enter one per request in
// row-major order, and vertices leave one row behind (the final row's inputs also
// emit that row), each with centered x/z positions, height in tenths and a Q2.14
// unit normal from central differences (border vertices get straight up). The front
// spends a read state and a write state per height byte on its two line-buffer RAMs,
// and takes no new byte until it is back in idle with room in the work queue. The
// back takes one request at a time and holds its output while the result queue is
// full. An interior vertex waits on a 15-bit digit recurrence (a candidate step and a
// compare-and-commit step per digit) that produces the exact rounded normal; interior
// vertices therefore set the sustained rate. A last-row byte yields two results and
// costs the back one more output state. The line buffers need no clearing after reset.
module heightmap_vertex_normal_stream_core import hvns_pkg::*; #(
    parameter int MAX_GRID = HVNS_MAX_GRID,
    localparam int CW  = $clog2(MAX_GRID),
    localparam int GW  = $clog2(MAX_GRID + 1),
    localparam int GEW = (GW > 11) ? GW : 11,
    localparam int TW  = 2 * CW + $bits(t_task),
    localparam int RW  = $bits(t_result)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Height input
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_height,
    // Vertex output
    output logic               empty,
    input  logic               pop,
    output logic signed [19:0] o_pos_x,
    output logic signed [8:0]  o_height_tenths,
    output logic signed [19:0] o_pos_z,
    output logic signed [15:0] o_normal_x,
    output logic signed [15:0] o_normal_y,
    output logic signed [15:0] o_normal_z,
    output logic               o_run_last,
    output logic               o_map_last,
    // Configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [10:0]        i_cfg_data
);

    logic [10:0]    r_grid_size;
    logic [9:0]     r_spacing;
    logic [GEW-1:0] eff_grid;
    logic [9:0]     eff_spacing;
    logic           cfg_wr;
    logic           restart;

    logic           task_full;
    logic           task_empty;
    logic           task_push;
    logic           task_pop;
    t_task          f_task;
    logic [CW-1:0]  f_col;
    logic [CW-1:0]  f_vrow;
    logic [TW-1:0]  task_dout;
    t_task          b_task;
    logic [CW-1:0]  b_col;
    logic [CW-1:0]  b_vrow;

    logic           res_full;
    logic           res_push;
    t_result        res_in;
    logic [RW-1:0]  res_dout;
    t_result        res_head;

    // Configuration registers
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign restart     = cfg_wr && (i_cfg_index == CFG_GRID_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= GRID_RESET;
            r_spacing   <= SPACING_RESET;
        end else if (cfg_wr) begin
            if (i_cfg_index == CFG_GRID_SIZE) begin
                r_grid_size <= i_cfg_data;
            end else if (i_cfg_index == CFG_SPACING) begin
                r_spacing <= i_cfg_data[9:0];
            end
        end
    end

    // Clamp the map edge and spacing to usable values
    always_comb begin
        if (r_grid_size < 11'd3) begin
            eff_grid = GEW'(3);
        end else if (GEW'(r_grid_size) > GEW'(MAX_GRID)) begin
            eff_grid = GEW'(MAX_GRID);
        end else begin
            eff_grid = GEW'(r_grid_size);
        end
    end
    assign eff_spacing = (r_spacing == '0) ? 10'd1 : r_spacing;

    hvns_front #(.MAX_GRID(MAX_GRID)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (restart),
        .i_grid      (eff_grid),
        .i_push      (push),
        .i_height    (i_height),
        .o_full      (full),
        .i_task_room (!task_full),
        .o_task_push (task_push),
        .o_task      (f_task),
        .o_col       (f_col),
        .o_vrow      (f_vrow)
    );

    // Work queue between front and back
    hvns_fifo #(.WIDTH(TW), .DEPTH(QUEUE_DEPTH)) u_task_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (task_push),
        .i_data  ({f_col, f_vrow, f_task}),
        .o_full  (task_full),
        .i_pop   (task_pop),
        .o_data  (task_dout),
        .o_empty (task_empty)
    );
    assign {b_col, b_vrow, b_task} = task_dout;

    hvns_back #(.MAX_GRID(MAX_GRID)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_grid       (eff_grid),
        .i_spacing    (eff_spacing),
        .i_task_valid (!task_empty),
        .i_task       (b_task),
        .i_col        (b_col),
        .i_vrow       (b_vrow),
        .o_task_pop   (task_pop),
        .i_res_room   (!res_full),
        .o_res_push   (res_push),
        .o_res        (res_in)
    );

    // Result queue facing the consumer
    hvns_fifo #(.WIDTH(RW), .DEPTH(QUEUE_DEPTH)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_dout),
        .o_empty (empty)
    );
    assign res_head = t_result'(res_dout);

    assign o_pos_x         = res_head.pos_x;
    assign o_height_tenths = res_head.height_tenths;
    assign o_pos_z         = res_head.pos_z;
    assign o_normal_x      = res_head.normal_x;
    assign o_normal_y      = res_head.normal_y;
    assign o_normal_z      = res_head.normal_z;
    assign o_run_last      = res_head.run_last;
    assign o_map_last      = res_head.map_last;

endmodule

>>> rtl/core/hvns_checker.sv
`include "heightmap_vertex_normal_stream_core_assert.svh"

module hvns_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               empty,
    input logic signed [15:0] o_normal_x,
    input logic signed [15:0] o_normal_y,
    input logic signed [15:0] o_normal_z,
    input logic               o_run_last,
    input logic               o_map_last
);

    // Nothing is offered right after reset
    `HVNS_ASSERT_NEXT(a_reset_empty, !i_rst_n, empty, "results offered after reset")

    // The map's final vertex ends its request's run
    `HVNS_ASSERT_NOW(a_map_last_run, !empty && o_map_last, o_run_last, "map_last without run_last")

    // The map's final vertex is a corner, so its normal points straight up
    `HVNS_ASSERT_NOW(a_map_last_up, !empty && o_map_last, o_normal_x == 16'sd0 && o_normal_y == 16'sd16384 && o_normal_z == 16'sd0, "corner normal not up")

    // The vertical normal component is always strictly positive
    `HVNS_ASSERT_NOW(a_normal_y_pos, !empty, !o_normal_y[15] && o_normal_y != 16'sd0, "normal_y not positive")

endmodule

bind heightmap_vertex_normal_stream_core hvns_checker u_hvns_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .empty      (empty),
    .o_normal_x (o_normal_x),
    .o_normal_y (o_normal_y),
    .o_normal_z (o_normal_z),
    .o_run_last (o_run_last),
    .o_map_last (o_map_last)
);

>>> bench/heightmap_vertex_normal_stream_core_tb.sv
`timescale 1ns / 100ps

module heightmap_vertex_normal_stream_core_tb;
    import hvns_pkg::*;

    // Directed stimulus row: height byte, optionally with its results typed in
    typedef struct {
        logic [7:0] hbyte;
        bit         typed;
        int         nres;
        t_result    vtx;
    } t_dir_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [7:0]         i_height = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [19:0] o_pos_x;
    logic signed [8:0]  o_height_tenths;
    logic signed [19:0] o_pos_z;
    logic signed [15:0] o_normal_x;
    logic signed [15:0] o_normal_y;
    logic signed [15:0] o_normal_z;
    logic               o_run_last;
    logic               o_map_last;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [10:0]        i_cfg_data = '0;

    // Shadow of the block: two line buffers, counters and registers
    logic [7:0] older_row [HVNS_MAX_GRID];
    logic [7:0] prev_row [HVNS_MAX_GRID];
    int         row_at;
    int         col_at;
    int         grid_reg;
    int         spacing_reg;

    t_result    vertex_q[$];
    int         err_count = 0;
    int         vertices_seen = 0;
    int         heights_sent = 0;
    int         maps_done = 0;
    bit         steady = 1'b0;

    heightmap_vertex_normal_stream_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_height       (i_height),
        .empty          (empty),
        .pop            (pop),
        .o_pos_x        (o_pos_x),
        .o_height_tenths(o_height_tenths),
        .o_pos_z        (o_pos_z),
        .o_normal_x     (o_normal_x),
        .o_normal_y     (o_normal_y),
        .o_normal_z     (o_normal_z),
        .o_run_last     (o_run_last),
        .o_map_last     (o_map_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("timeout with %0d vertices outstanding", vertex_q.size());
        $display("TEST FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        err_count++;
        $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
    endtask

    function automatic int eff_grid();
        if (grid_reg < 3) return 3;
        if (grid_reg > HVNS_MAX_GRID) return HVNS_MAX_GRID;
        return grid_reg;
    endfunction

    function automatic int eff_spacing();
        return (spacing_reg == 0) ? 1 : spacing_reg;
    endfunction

    // Rounded v*16384/|n|, exact: largest m with (2m-1)^2 * n2 <= v^2 * 2^30
    function automatic longint unit_normal_comp(input longint v, input longint unsigned n2);
        longint unsigned av, lim, lo, hi, mid, t;
        av = (v < 0) ? -v : v;
        lim = (av * av) << 30;
        lo = 0;
        hi = 16384;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t = 2 * mid - 1;
            if (t * t * n2 <= lim) lo = mid;
            else hi = mid - 1;
        end
        return (v < 0) ? -longint'(lo) : longint'(lo);
    endfunction

    function automatic t_result make_vertex(input int col, input int row, input int hb,
                                            input longint nx, input longint ny,
                                            input longint nz, input bit rl, input bit ml);
        t_result r;
        int half;
        half = ((eff_grid() - 1) * eff_spacing()) / 2;
        r.pos_x = 20'(col * eff_spacing() - half);
        r.height_tenths = 9'(hb - 100);
        r.pos_z = 20'(row * eff_spacing() - half);
        r.normal_x = 16'(nx);
        r.normal_y = 16'(ny);
        r.normal_z = 16'(nz);
        r.run_last = rl;
        r.map_last = ml;
        return r;
    endfunction

    // Advance the shadow by one height byte; returns the vertices it emits
    function automatic int predict_vertices(input logic [7:0] hb, output t_result v0,
                                            output t_result v1);
        int g, r, c, n, center, down;
        longint vx, vy, vz, nx, ny, nz;
        longint unsigned n2;
        bit last_row;
        g = eff_grid();
        r = row_at;
        c = col_at;
        n = 0;
        v0 = '0;
        v1 = '0;
        if (r >= g || c >= g) begin
            r = 0;
            c = 0;
        end
        if (r >= 1) begin
            center = int'(prev_row[c]);
            down = int'(older_row[c]);
            last_row = (r == g - 1);
            nx = 0;
            ny = 16384;
            nz = 0;
            older_row[c] = 8'(center);
            // central differences only away from the border
            if (r - 1 >= 1 && c >= 1 && c + 1 < g) begin
                vx = longint'(older_row[c - 1]) - longint'(prev_row[c + 1]);
                vy = longint'(20 * eff_spacing());
                vz = longint'(down) - longint'(hb);
                n2 = vx * vx + vy * vy + vz * vz;
                nx = unit_normal_comp(vx, n2);
                ny = unit_normal_comp(vy, n2);
                nz = unit_normal_comp(vz, n2);
            end
            v0 = make_vertex(c, r - 1, center, nx, ny, nz, !last_row, 1'b0);
            n = 1;
            if (last_row) begin
                v1 = make_vertex(c, r, int'(hb), 0, 16384, 0, 1'b1, c == g - 1);
                n = 2;
            end
        end else begin
            older_row[c] = prev_row[c];
        end
        prev_row[c] = hb;
        c++;
        if (c >= g) begin
            c = 0;
            r++;
            if (r >= g) r = 0;
        end
        row_at = r;
        col_at = c;
        return n;
    endfunction

    // Drive one height request and hold it until accepted
    task automatic send_height(input logic [7:0] hb, input bit typed = 1'b0,
                               input int typed_n = 0, input t_result typed_v = '0);
        t_result v0, v1;
        int n;
        while (!steady && $urandom_range(99) < 36) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_height <= hb;
        do @(posedge i_clk); while (full);
        heights_sent++;
        n = predict_vertices(hb, v0, v1);
        if (typed) begin
            if (n != typed_n) report_mismatch("vertex count of typed row", n, typed_n);
            if (typed_n > 0) vertex_q = {vertex_q, typed_v};
        end else begin
            if (n > 0) vertex_q = {vertex_q, v0};
            if (n > 1) vertex_q = {vertex_q, v1};
        end
    endtask

    // Let all pending vertices drain, then allow for work still in flight
    task automatic drain_vertices();
        push <= 1'b0;
        while (vertex_q.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input int val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 11'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_GRID_SIZE) begin
            grid_reg = val & 'h7FF;
            row_at = 0;
            col_at = 0;
        end else begin
            spacing_reg = val & 'h3FF;
        end
        @(posedge i_clk);
    endtask

    // Vertex checker
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && pop && !empty) begin
            vertices_seen++;
            if (vertex_q.size() == 0) begin
                err_count++;
                $display("%0t unexpected vertex at x %0d z %0d", $time, o_pos_x, o_pos_z);
            end else begin
                e = vertex_q.pop_front();
                if (o_pos_x !== e.pos_x) report_mismatch("pos_x", o_pos_x, e.pos_x);
                if (o_height_tenths !== e.height_tenths)
                    report_mismatch("height_tenths", o_height_tenths, e.height_tenths);
                if (o_pos_z !== e.pos_z) report_mismatch("pos_z", o_pos_z, e.pos_z);
                if (o_normal_x !== e.normal_x)
                    report_mismatch("normal_x", o_normal_x, e.normal_x);
                if (o_normal_y !== e.normal_y)
                    report_mismatch("normal_y", o_normal_y, e.normal_y);
                if (o_normal_z !== e.normal_z)
                    report_mismatch("normal_z", o_normal_z, e.normal_z);
                if (o_run_last !== e.run_last)
                    report_mismatch("run_last", o_run_last, e.run_last);
                if (o_map_last !== e.map_last)
                    report_mismatch("map_last", o_map_last, e.map_last);
            end
        end
        pop <= i_rst_n && (steady || $urandom_range(99) >= 36);
    end

    initial begin
        t_dir_row dir_tab[9];
        int g, span, count, mode;
        logic [7:0] hb;

        foreach (older_row[k]) begin
            older_row[k] = '0;
            prev_row[k] = '0;
        end
        row_at = 0;
        col_at = 0;
        grid_reg = GRID_RESET;
        spacing_reg = SPACING_RESET;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 3x3 map, spacing 1: top row is silent, middle row emits the border top row
        cfg_write(CFG_GRID_SIZE, 3);
        cfg_write(CFG_SPACING, 1);
        dir_tab[0] = '{8'd0,   1'b1, 0, '0};
        dir_tab[1] = '{8'd255, 1'b1, 0, '0};
        dir_tab[2] = '{8'd128, 1'b1, 0, '0};
        dir_tab[3] = '{8'd255, 1'b1, 1, '{-20'sd1, -9'sd100, -20'sd1, 16'sd0, 16'sd16384,
                                          16'sd0, 1'b1, 1'b0}};
        dir_tab[4] = '{8'd0,   1'b1, 1, '{20'sd0, 9'sd155, -20'sd1, 16'sd0, 16'sd16384,
                                          16'sd0, 1'b1, 1'b0}};
        dir_tab[5] = '{8'd7,   1'b1, 1, '{20'sd1, 9'sd28, -20'sd1, 16'sd0, 16'sd16384,
                                          16'sd0, 1'b1, 1'b0}};
        dir_tab[6] = '{8'd255, 1'b0, 0, '0};
        dir_tab[7] = '{8'd0,   1'b0, 0, '0};
        dir_tab[8] = '{8'd255, 1'b0, 0, '0};
        foreach (dir_tab[k])
            send_height(dir_tab[k].hbyte, dir_tab[k].typed, dir_tab[k].nres, dir_tab[k].vtx);
        drain_vertices();

        // Clamped low grid and zero spacing
        cfg_write(CFG_GRID_SIZE, 2);
        cfg_write(CFG_SPACING, 0);
        for (int k = 0; k < 9; k++) send_height((k % 2) ? 8'd255 : 8'd0);
        drain_vertices();

        // Steep slopes at the widest spacing on a 4x4 map
        cfg_write(CFG_GRID_SIZE, 4);
        cfg_write(CFG_SPACING, 1023);
        for (int k = 0; k < 16; k++) send_height(((k / 4 + k) % 2) ? 8'd255 : 8'd0);
        drain_vertices();

        // Random maps, mostly small and complete; some cut short, some respaced midway
        count = 0;
        while (count < 516) begin
            steady = (maps_done % 12 == 5);
            g = ($urandom_range(19) == 0) ? $urandom_range(8, 12) : $urandom_range(3, 7);
            if (steady) g = 10;
            cfg_write(CFG_GRID_SIZE, g);
            mode = $urandom_range(9);
            case ($urandom_range(5))
                0: cfg_write(CFG_SPACING, 1023);
                1: cfg_write(CFG_SPACING, $urandom_range(1));
                default: cfg_write(CFG_SPACING, $urandom_range(1023));
            endcase
            span = g * g;
            if (mode == 0) span = $urandom_range(1, g * g - 1);
            if (span > 516 - count) span = 516 - count;
            for (int k = 0; k < span; k++) begin
                if (mode == 1 && k == span / 2) begin
                    drain_vertices();
                    cfg_write(CFG_SPACING, $urandom_range(1023));
                end
                case ($urandom_range(7))
                    0: hb = 8'd0;
                    1: hb = 8'd255;
                    default: hb = 8'($urandom_range(255));
                endcase
                send_height(hb);
            end
            count += span;
            maps_done++;
            steady = 1'b0;
            drain_vertices();
        end

        push <= 1'b0;
        while (vertex_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("sent %0d height bytes over %0d random maps plus directed maps", heights_sent,
                 maps_done);
        $display("checked %0d vertices, %0d mismatches", vertices_seen, err_count);
        if (err_count == 0 && vertex_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> heightmap_vertex_normal_stream_core.f
+incdir+rtl/core
rtl/core/hvns_pkg.sv
rtl/core/hvns_ram.sv
rtl/core/hvns_fifo.sv
rtl/core/hvns_front.sv
rtl/core/hvns_norm.sv
rtl/core/hvns_back.sv
rtl/core/heightmap_vertex_normal_stream_core.sv
rtl/core/hvns_checker.sv
bench/heightmap_vertex_normal_stream_core_tb.sv
